>>> rtl/afs_pkg.sv
// Package: shared constants and types for the aspect fit size scaler
`timescale 1ns / 1ps
package afs_pkg;
  localparam int DIM_BITS  = 16;
  localparam int FIELD_W   = 16;
  localparam int PROD_W    = 2 * FIELD_W;
  localparam int NUM_W     = PROD_W + 2;
  localparam int DEN_W     = FIELD_W + 1;
  localparam int QUO_W     = NUM_W;
  localparam int DIV_STEPS = QUO_W;
  localparam logic [FIELD_W-1:0] DIM_MAX =
    (DIM_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << DIM_BITS) - 64'd1);

  typedef enum logic [1:0] {
    MODE_FIT_DOWN  = 2'd0,
    MODE_FIT       = 2'd1,
    MODE_CONTAIN   = 2'd2,
    MODE_CONTAIN_UP = 2'd3
  } mode_t;

  // Per-item context carried alongside the divider
  typedef struct packed {
    logic               x_side;
    logic               same;
    logic [FIELD_W-1:0] pass_w;
    logic [FIELD_W-1:0] pass_h;
  } ctx_t;
endpackage

>>> rtl/afs_front.sv
// Front stages: cross products, mode decision, dividend and divisor setup
`timescale 1ns / 1ps
module afs_front import afs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         cmd,
  input  logic [FIELD_W-1:0] src_width,
  input  logic [FIELD_W-1:0] src_height,
  input  logic [FIELD_W-1:0] box_width,
  input  logic [FIELD_W-1:0] box_height,
  output logic               op_valid,
  output logic [NUM_W-1:0]   op_num,
  output logic [DEN_W-1:0]   op_den,
  output ctx_t               op_ctx
);
  // stage 1: register inputs and cross products
  logic               v1;
  logic [1:0]         m1;
  logic [FIELD_W-1:0] sw1, sh1, bw1, bh1;
  logic [PROD_W-1:0]  lx1, ly1;
  logic               empty1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    m1     <= cmd;
    sw1    <= src_width;
    sh1    <= src_height;
    bw1    <= box_width;
    bh1    <= box_height;
    lx1    <= box_width * src_height;
    ly1    <= box_height * src_width;
    empty1 <= (src_width == '0) || (src_height == '0) ||
              (box_width == '0) || (box_height == '0);
  end

  // side choice and pass-through decision
  logic x_side_c, same_c;
  always_comb begin
    if (m1 == MODE_FIT_DOWN || m1 == MODE_FIT) x_side_c = lx1 < ly1;
    else                                        x_side_c = lx1 > ly1;
    same_c = 1'b0;
    if (empty1) same_c = 1'b1;
    else if (m1 == MODE_FIT_DOWN)
      same_c = x_side_c ? (bw1 >= sw1) : (bh1 >= sh1);
    else if (m1 == MODE_CONTAIN_UP)
      same_c = x_side_c ? (bw1 <= sw1) : (bh1 <= sh1);
  end

  // stage 2: dividend 2*a*b + c, divisor 2*c
  logic [FIELD_W-1:0] den_c;
  logic [PROD_W-1:0]  prod_c;
  assign den_c  = x_side_c ? sw1 : sh1;
  assign prod_c = x_side_c ? lx1 : ly1;

  // a side comes from the box only when the item is scaled
  always_ff @(posedge clk) begin
    if (rst) op_valid <= 1'b0;
    else     op_valid <= v1;
    op_num        <= {1'b0, prod_c, 1'b0} + NUM_W'(den_c);
    op_den        <= {den_c, 1'b0};
    op_ctx.x_side <= x_side_c;
    op_ctx.same   <= same_c;
    op_ctx.pass_w <= (x_side_c && !same_c) ? bw1 : sw1;
    op_ctx.pass_h <= (!x_side_c && !same_c) ? bh1 : sh1;
  end
endmodule

>>> rtl/afs_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module afs_div import afs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  ctx_t             in_ctx,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output ctx_t             out_ctx
);
  logic [DIV_STEPS:0]   v;
  logic [NUM_W-1:0]     q   [DIV_STEPS+1];
  logic [DEN_W:0]       r   [DIV_STEPS+1];
  logic [DEN_W-1:0]     d   [DIV_STEPS+1];
  ctx_t                 c   [DIV_STEPS+1];

  assign v[0] = in_valid;
  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign c[0] = in_ctx;

  // each stage shifts in one dividend bit and trial-subtracts
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
    logic [DEN_W:0] sh_c, sub_c;
    logic           ge_c;
    assign sh_c  = {r[i][DEN_W-1:0], q[i][NUM_W-1]};
    assign ge_c  = sh_c >= {1'b0, d[i]};
    assign sub_c = sh_c - {1'b0, d[i]};
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else     v[i+1] <= v[i];
      r[i+1] <= ge_c ? sub_c : sh_c;
      q[i+1] <= {q[i][NUM_W-2:0], ge_c};
      d[i+1] <= d[i];
      c[i+1] <= c[i];
    end
  end

  assign out_valid = v[DIV_STEPS];
  assign quo       = q[DIV_STEPS];
  assign out_ctx   = c[DIV_STEPS];
endmodule

>>> rtl/afs_back.sv
// Back stage: result select, clamp to the dimension maximum, output register
`timescale 1ns / 1ps
module afs_back import afs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [QUO_W-1:0]   quo,
  input  ctx_t               in_ctx,
  output logic               done,
  output logic [FIELD_W-1:0] out_width,
  output logic [FIELD_W-1:0] out_height,
  output logic               unchanged,
  output logic               saturated
);
  logic [QUO_W-1:0] w_c, h_c;
  logic             sw_c, sh_c;
  always_comb begin
    w_c = QUO_W'(in_ctx.pass_w);
    h_c = QUO_W'(in_ctx.pass_h);
    if (!in_ctx.same) begin
      if (in_ctx.x_side) h_c = quo;
      else               w_c = quo;
    end
    sw_c = w_c > QUO_W'(DIM_MAX);
    sh_c = h_c > QUO_W'(DIM_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= in_valid;
    out_width  <= sw_c ? DIM_MAX : w_c[FIELD_W-1:0];
    out_height <= sh_c ? DIM_MAX : h_c[FIELD_W-1:0];
    unchanged  <= in_ctx.same;
    saturated  <= sw_c || sh_c;
  end
endmodule

>>> rtl/aspect_fit_size_scaler.sv
// Top level of the aspect fit size scaler
// Usage:
//   Drive cmd and the four sizes with start high; the item is taken at any
//   edge where start is high (busy is always low, the pipeline never
//   blocks). One item may enter every cycle.
//   Each item yields one result on out_width/out_height/unchanged/saturated
//   with done high for exactly one cycle, in input order.
//   Stages: 2 front stages (cross products, decision and setup), 34 divider
//   stages (one quotient bit each over a 34-bit dividend), 1 output stage.
//   Throughput: one item per cycle, set by the fully pipelined divider.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall: results must be taken when done is high.
//   Modes: 0 fit down only, 1 fit, 2 contain, 3 contain up only.
//   An empty source or box passes the source through with unchanged set;
//   sides above the dimension maximum clamp and set saturated.
`timescale 1ns / 1ps
module aspect_fit_size_scaler import afs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [FIELD_W-1:0] src_width,
  input  logic [FIELD_W-1:0] src_height,
  input  logic [FIELD_W-1:0] box_width,
  input  logic [FIELD_W-1:0] box_height,
  output logic               done,
  output logic [FIELD_W-1:0] out_width,
  output logic [FIELD_W-1:0] out_height,
  output logic               unchanged,
  output logic               saturated
);
  logic             op_valid, dv_valid;
  logic [NUM_W-1:0] op_num;
  logic [DEN_W-1:0] op_den;
  logic [QUO_W-1:0] quo;
  ctx_t             op_ctx, dv_ctx;

  assign busy = 1'b0;

  afs_front u_front (
    .clk, .rst, .in_valid(start && !busy), .cmd, .src_width, .src_height,
    .box_width, .box_height, .op_valid, .op_num, .op_den, .op_ctx
  );

  afs_div u_div (
    .clk, .rst, .in_valid(op_valid), .num(op_num), .den(op_den),
    .in_ctx(op_ctx), .out_valid(dv_valid), .quo, .out_ctx(dv_ctx)
  );

  afs_back u_back (
    .clk, .rst, .in_valid(dv_valid), .quo, .in_ctx(dv_ctx), .done,
    .out_width, .out_height, .unchanged, .saturated
  );
endmodule

>>> rtl/afs_checker.sv
// Port-level checker for the aspect fit size scaler, bound to the top level
`timescale 1ns / 1ps
module afs_checker import afs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [FIELD_W-1:0] out_width,
  input logic [FIELD_W-1:0] out_height,
  input logic               saturated
);
  // the pipeline never blocks
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  // a result after reset needs an accepted item earlier in the pipeline
  a_done_after_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 37)) else $error("result without item");
  // every accepted item gives a result
  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##37 done) else $error("item lost");
  // clamped sides sit at the maximum
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (out_width == DIM_MAX || out_height == DIM_MAX))
    else $error("saturated without clamp");
endmodule

bind aspect_fit_size_scaler afs_checker u_afs_checker (
  .clk, .rst, .start, .busy, .done, .out_width, .out_height, .saturated
);
